// File: design/cofr_pkg.sv
package cofr_pkg;

  // Size of the command and of the drawing space.
  localparam int MAX_DIAMETER = 20;
  localparam int COORD_W      = 16;
  localparam int OUT_W        = 16;
  localparam int DIAM_W       = 5;
  localparam int ANC_W        = 3;
  localparam int RUN_W        = 5;
  localparam int INK_W        = 16;

  // Walk offsets stay at or below radius + 1.
  localparam int STEP_W     = $clog2(MAX_DIAMETER / 2 + 2);
  localparam int SQ_W       = 2 * STEP_W + 1;
  localparam int MAX_WRITES = 56;
  localparam int CNT_W      = $clog2(MAX_WRITES + 1);
  localparam int THR_W      = 3;

  typedef enum logic [ANC_W-1:0] {
    ANC_TL  = 3'd0,
    ANC_TR  = 3'd1,
    ANC_BL  = 3'd2,
    ANC_BR  = 3'd3,
    ANC_CTR = 3'd4
  } anchor_t;

  typedef enum logic [2:0] {
    OP_WAIT,
    OP_ANCHOR,
    OP_CENTRE,
    OP_UPDATE,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    SQ_NEXT,
    SQ_ACCEPT,
    SQ_CHECK,
    SQ_DISPATCH,
    SQ_EMIT,
    SQ_LOOP
  } seq_t;

  // One control word: operation, sequencing, and how an emit step forms its write.
  typedef struct packed {
    op_t  op;
    seq_t seq;
    logic x_hi;
    logic swap;
    logic x_neg;
    logic y_hi;
    logic y_neg;
  } uword_t;

  localparam int PC_W = 5;

  localparam logic [PC_W-1:0] PC_IDLE   = 5'd0;
  localparam logic [PC_W-1:0] PC_ANCHOR = 5'd1;
  localparam logic [PC_W-1:0] PC_CENTRE = 5'd2;
  localparam logic [PC_W-1:0] PC_UPDATE = 5'd3;
  localparam logic [PC_W-1:0] PC_EO     = 5'd4;   // even outline, eight words
  localparam logic [PC_W-1:0] PC_EF     = 5'd12;  // even fill, four words
  localparam logic [PC_W-1:0] PC_OO     = 5'd16;  // odd outline, eight words
  localparam logic [PC_W-1:0] PC_OF     = 5'd24;  // odd fill, four words
  localparam logic [PC_W-1:0] PC_LAST   = 5'd27;

  localparam logic [PC_W-1:0] PC_ONE = 5'd1;

  // Bits of f are {x_hi, swap, x_neg, y_hi, y_neg}.
  function automatic uword_t uw_emit(input logic last, input logic [4:0] f);
    uword_t w;
    w.op    = OP_EMIT;
    w.seq   = last ? SQ_LOOP : SQ_EMIT;
    w.x_hi  = f[4];
    w.swap  = f[3];
    w.x_neg = f[2];
    w.y_hi  = f[1];
    w.y_neg = f[0];
    return w;
  endfunction

  function automatic uword_t uw_ctl(input op_t op, input seq_t seq);
    uword_t w;
    w       = '0;
    w.op    = op;
    w.seq   = seq;
    return w;
  endfunction

  // The control store.
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      PC_IDLE:              w = uw_ctl(OP_WAIT, SQ_ACCEPT);
      PC_ANCHOR:            w = uw_ctl(OP_ANCHOR, SQ_CHECK);
      PC_CENTRE:            w = uw_ctl(OP_CENTRE, SQ_NEXT);
      PC_UPDATE:            w = uw_ctl(OP_UPDATE, SQ_DISPATCH);
      PC_EO:                w = uw_emit(1'b0, 5'b00101);
      PC_EO + 5'd1:         w = uw_emit(1'b0, 5'b01101);
      PC_EO + 5'd2:         w = uw_emit(1'b0, 5'b10001);
      PC_EO + 5'd3:         w = uw_emit(1'b0, 5'b11001);
      PC_EO + 5'd4:         w = uw_emit(1'b0, 5'b00110);
      PC_EO + 5'd5:         w = uw_emit(1'b0, 5'b01110);
      PC_EO + 5'd6:         w = uw_emit(1'b0, 5'b10010);
      PC_EO + 5'd7:         w = uw_emit(1'b1, 5'b11010);
      PC_EF:                w = uw_emit(1'b0, 5'b00101);
      PC_EF + 5'd1:         w = uw_emit(1'b0, 5'b01101);
      PC_EF + 5'd2:         w = uw_emit(1'b0, 5'b00110);
      PC_EF + 5'd3:         w = uw_emit(1'b1, 5'b01110);
      PC_OO:                w = uw_emit(1'b0, 5'b00001);
      PC_OO + 5'd1:         w = uw_emit(1'b0, 5'b00000);
      PC_OO + 5'd2:         w = uw_emit(1'b0, 5'b00101);
      PC_OO + 5'd3:         w = uw_emit(1'b0, 5'b00100);
      PC_OO + 5'd4:         w = uw_emit(1'b0, 5'b01100);
      PC_OO + 5'd5:         w = uw_emit(1'b0, 5'b01101);
      PC_OO + 5'd6:         w = uw_emit(1'b0, 5'b01000);
      PC_OO + 5'd7:         w = uw_emit(1'b1, 5'b01001);
      PC_OF:                w = uw_emit(1'b0, 5'b00101);
      PC_OF + 5'd1:         w = uw_emit(1'b0, 5'b01101);
      PC_OF + 5'd2:         w = uw_emit(1'b0, 5'b00100);
      PC_OF + 5'd3:         w = uw_emit(1'b1, 5'b01100);
      default:              w = uw_ctl(OP_WAIT, SQ_ACCEPT);
    endcase
    return w;
  endfunction

  // Step threshold on the squared distance error, by diameter parity and radius.
  function automatic logic [THR_W-1:0] step_thr(input logic even,
                                                input logic [STEP_W-1:0] h);
    logic [THR_W-1:0] t;
    if (even) begin
      if (h <= STEP_W'(3)) t = 3'd0;
      else if (h <= STEP_W'(6)) t = 3'd3;
      else t = 3'd5;
    end else begin
      if (h == STEP_W'(1)) t = 3'd0;
      else if (h == STEP_W'(2)) t = 3'd1;
      else if (h == STEP_W'(3)) t = 3'd3;
      else t = 3'd5;
    end
    return t;
  endfunction

endpackage

// File: design/circle_outline_and_fill_rasterizer_top.sv
// Circle rasterizer: takes one circle command word on the in_ channel and
// produces a stream of pixel or span write words on the out_ channel.
// A command carries an anchor position, a diameter, an anchor code, an ink
// value and an outline/fill choice. The anchor is resolved to the circle's
// middle, then a midpoint octant walk runs; every walk step gives eight pixel
// words (outline) or four horizontal span words (fill). The last word of a
// command has out_final_write set. Diameter zero, a diameter above the
// maximum, or an anchor code above the centre code produce no words at all.
// Control is a small microprogram: a step counter walks a read-only table of
// control words, with a conditional jump at the end of each walk step.
// After a command is accepted, the sequencer runs an anchor step, a centre
// step and an update step before its first emit step loads the first write
// word into the output register. Each walk step is one update step followed
// by one emit step per write word. The sequencer holds one command at a time,
// so in_stall stays high from accept until its last word has been loaded into
// the output register, or until a dropped command fails its check.
// When out_stall is high while the output register holds a word, it keeps
// the word and the sequencer waits on that emit step. Reset (rst_n low,
// synchronous) returns the sequencer to idle and empties the output register.
module circle_outline_and_fill_rasterizer_top
  import cofr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,

  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [OUT_W-1:0] in_pos_x,
  input  logic signed [OUT_W-1:0] in_pos_y,
  input  logic [DIAM_W-1:0]       in_diam,
  input  logic [ANC_W-1:0]        in_anchor,
  input  logic                    in_solid,
  input  logic [INK_W-1:0]        in_ink,

  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] out_write_x,
  output logic signed [OUT_W-1:0] out_write_y,
  output logic [RUN_W-1:0]        out_run_length,
  output logic                    out_is_span,
  output logic [INK_W-1:0]        out_write_ink,
  output logic                    out_final_write
);

  // Sequencer.
  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  uword_t          uw;

  // Latched command.
  logic [COORD_W-1:0] cmd_x_r;
  logic [COORD_W-1:0] cmd_y_r;
  logic [DIAM_W-1:0]  cmd_d_r;
  logic [ANC_W-1:0]   cmd_anc_r;
  logic               fill_mode_r;
  logic [INK_W-1:0]   held_ink_r;

  // Resolved geometry.
  logic               even_mode_r;
  logic [STEP_W-1:0]  rad_r;
  logic [THR_W-1:0]   limit_r;
  logic [COORD_W-1:0] base_x_r;
  logic [COORD_W-1:0] base_y_r;
  logic [COORD_W-1:0] lo_x_r;
  logic [COORD_W-1:0] hi_x_r;
  logic [COORD_W-1:0] lo_y_r;
  logic [COORD_W-1:0] hi_y_r;
  logic [STEP_W-1:0]  rr_r;

  // Walk state: step_y_r holds the magnitude of the (negative) y offset.
  logic [STEP_W-1:0]  step_x_r;
  logic [STEP_W-1:0]  step_y_r;
  logic [STEP_W-1:0]  next_x_r;
  logic [STEP_W-1:0]  next_y_r;
  logic               cont_r;
  logic [CNT_W-1:0]   wr_cnt_r;

  // Output register.
  logic                    out_valid_r;
  logic signed [OUT_W-1:0] out_x_r;
  logic signed [OUT_W-1:0] out_y_r;
  logic [RUN_W-1:0]        out_len_r;
  logic                    out_span_r;
  logic [INK_W-1:0]        out_ink_r;
  logic                    out_final_r;

  // Combinational datapath.
  logic               in_fire;
  logic               out_free;
  logic               emit_fire;
  logic               cmd_bad;
  logic [STEP_W-1:0]  h;
  logic [COORD_W-1:0] d_c;
  logic [COORD_W-1:0] h_c;
  logic [COORD_W-1:0] bx;
  logic [COORD_W-1:0] by;
  logic [COORD_W-1:0] mid_off;
  logic [COORD_W-1:0] mid_off_lo;
  logic [STEP_W-1:0]  xn;
  logic [2*STEP_W-1:0] x_sq;
  logic [2*STEP_W-1:0] y_sq;
  logic [2*STEP_W-1:0] r_sq;
  logic               y_dec;
  logic [STEP_W:0]    cont_lhs;
  logic [CNT_W:0]     cnt_after;
  logic [CNT_W-1:0]   per_step;
  logic [STEP_W-1:0]  x_off;
  logic [STEP_W-1:0]  y_off;
  logic [COORD_W-1:0] x_base;
  logic [COORD_W-1:0] y_base;
  logic [COORD_W-1:0] x_val;
  logic [COORD_W-1:0] y_val;
  logic [RUN_W-1:0]   run_len;
  logic [STEP_W+1:0]  span_len;

  assign uw        = ucode(pc_r);
  assign in_stall  = (pc_r != PC_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign emit_fire = (uw.op == OP_EMIT) && out_free;

  // Anchor resolution: even diameters give the top-left corner of the box,
  // odd diameters give the true centre pixel.
  always_comb begin
    cmd_bad = (cmd_d_r == '0) || (cmd_d_r > DIAM_W'(MAX_DIAMETER)) ||
              (cmd_anc_r > ANC_CTR);
    h   = STEP_W'(cmd_d_r >> 1);
    d_c = COORD_W'(cmd_d_r);
    h_c = COORD_W'(h);
    if (!cmd_d_r[0]) begin
      if (cmd_anc_r == ANC_TR || cmd_anc_r == ANC_BR) bx = cmd_x_r - d_c;
      else if (cmd_anc_r == ANC_CTR) bx = cmd_x_r - h_c;
      else bx = cmd_x_r;
      if (cmd_anc_r == ANC_BL || cmd_anc_r == ANC_BR) by = cmd_y_r - d_c;
      else if (cmd_anc_r == ANC_CTR) by = cmd_y_r - h_c;
      else by = cmd_y_r;
    end else begin
      if (cmd_anc_r == ANC_TL || cmd_anc_r == ANC_BL) bx = cmd_x_r + h_c;
      else if (cmd_anc_r == ANC_CTR) bx = cmd_x_r;
      else bx = cmd_x_r - h_c;
      if (cmd_anc_r == ANC_TL || cmd_anc_r == ANC_TR) by = cmd_y_r + h_c;
      else if (cmd_anc_r == ANC_CTR) by = cmd_y_r;
      else by = cmd_y_r - h_c;
    end
  end

  // Even circles have a 2x2 middle: lo is the upper-left pixel, hi the other.
  assign mid_off    = even_mode_r ? COORD_W'(rad_r) : '0;
  assign mid_off_lo = even_mode_r ? COORD_W'(rad_r) - COORD_W'(1) : '0;

  // Walk update: step y when x^2 + y^2 exceeds r^2 plus the threshold.
  // The walk continues while x stays at or below |y| and the write budget
  // has room for one more step.
  always_comb begin
    xn        = step_x_r + STEP_W'(1);
    x_sq      = xn * xn;
    y_sq      = step_y_r * step_y_r;
    r_sq      = rr_r * rr_r;
    y_dec     = (SQ_W'(x_sq) + SQ_W'(y_sq)) > (SQ_W'(r_sq) + SQ_W'(limit_r));
    cont_lhs  = {1'b0, xn} + (STEP_W+1)'(y_dec);
    per_step  = fill_mode_r ? CNT_W'(4) : CNT_W'(8);
    cnt_after = {1'b0, wr_cnt_r} + {1'b0, per_step} + {1'b0, per_step};
  end

  // Emit datapath: one adder per axis, steered by the control word.
  always_comb begin
    x_off    = uw.swap ? step_y_r : step_x_r;
    y_off    = uw.swap ? step_x_r : step_y_r;
    x_base   = uw.x_hi ? hi_x_r : lo_x_r;
    y_base   = uw.y_hi ? hi_y_r : lo_y_r;
    x_val    = uw.x_neg ? x_base - COORD_W'(x_off) : x_base + COORD_W'(x_off);
    y_val    = uw.y_neg ? y_base - COORD_W'(y_off) : y_base + COORD_W'(y_off);
    span_len = {1'b0, x_off, 1'b0} + (STEP_W+2)'(even_mode_r ? 2 : 1);
    run_len  = fill_mode_r ? RUN_W'(span_len) : RUN_W'(1);
  end

  // Step counter and jumps.
  always_comb begin
    pc_nxt = pc_r;
    unique case (uw.seq)
      SQ_NEXT:   pc_nxt = pc_r + PC_ONE;
      SQ_ACCEPT: pc_nxt = in_fire ? PC_ANCHOR : PC_IDLE;
      SQ_CHECK:  pc_nxt = cmd_bad ? PC_IDLE : pc_r + PC_ONE;
      SQ_DISPATCH: begin
        unique case ({even_mode_r, fill_mode_r})
          2'b10:   pc_nxt = PC_EO;
          2'b11:   pc_nxt = PC_EF;
          2'b00:   pc_nxt = PC_OO;
          default: pc_nxt = PC_OF;
        endcase
      end
      SQ_EMIT:   pc_nxt = out_free ? pc_r + PC_ONE : pc_r;
      SQ_LOOP: begin
        if (out_free) pc_nxt = cont_r ? PC_UPDATE : PC_IDLE;
      end
      default:   pc_nxt = PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PC_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      if (emit_fire) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (uw.op)
      OP_WAIT: begin
        if (in_fire) begin
          cmd_x_r     <= in_pos_x[COORD_W-1:0];
          cmd_y_r     <= in_pos_y[COORD_W-1:0];
          cmd_d_r     <= in_diam;
          cmd_anc_r   <= in_anchor;
          fill_mode_r <= in_solid;
          held_ink_r  <= in_ink;
        end
      end
      OP_ANCHOR: begin
        even_mode_r <= !cmd_d_r[0];
        rad_r       <= h;
        limit_r     <= step_thr(!cmd_d_r[0], h);
        base_x_r    <= bx;
        base_y_r    <= by;
      end
      OP_CENTRE: begin
        lo_x_r   <= base_x_r + mid_off_lo;
        hi_x_r   <= base_x_r + mid_off;
        lo_y_r   <= base_y_r + mid_off_lo;
        hi_y_r   <= base_y_r + mid_off;
        rr_r     <= even_mode_r ? rad_r - STEP_W'(1) : rad_r;
        step_x_r <= '0;
        step_y_r <= even_mode_r ? rad_r - STEP_W'(1) : rad_r;
        wr_cnt_r <= '0;
      end
      OP_UPDATE: begin
        next_x_r <= xn;
        next_y_r <= step_y_r - STEP_W'(y_dec);
        cont_r   <= (cont_lhs <= {1'b0, step_y_r}) &&
                    (cnt_after <= (CNT_W+1)'(MAX_WRITES));
      end
      OP_EMIT: begin
        if (out_free) begin
          out_x_r     <= OUT_W'(signed'(x_val));
          out_y_r     <= OUT_W'(signed'(y_val));
          out_len_r   <= run_len;
          out_span_r  <= fill_mode_r;
          out_ink_r   <= held_ink_r;
          out_final_r <= (uw.seq == SQ_LOOP) && !cont_r;
          wr_cnt_r    <= wr_cnt_r + CNT_W'(1);
          if (uw.seq == SQ_LOOP) begin
            step_x_r <= next_x_r;
            step_y_r <= next_y_r;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_write_x     = out_x_r;
  assign out_write_y     = out_y_r;
  assign out_run_length  = out_len_r;
  assign out_is_span     = out_span_r;
  assign out_write_ink   = out_ink_r;
  assign out_final_write = out_final_r;

`ifndef NO_ASSERTIONS
  // The step counter never leaves the control store.
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= PC_LAST)
    else $error("step counter outside control store");

  // An accepted command always starts at the anchor step.
  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> pc_r == PC_ANCHOR)
    else $error("accepted command did not start its program");

  // Every emitted walk step lies inside its octant.
  a_octant: assert property (@(posedge clk) disable iff (!rst_n)
    (uw.op == OP_EMIT) |-> step_x_r <= step_y_r)
    else $error("walk step outside octant");

  // The write budget is never overrun.
  a_budget: assert property (@(posedge clk) disable iff (!rst_n)
    (uw.op == OP_EMIT) |-> wr_cnt_r < CNT_W'(MAX_WRITES))
    else $error("write budget exceeded");

  // The final word of a command returns the sequencer to idle.
  a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_fire && uw.seq == SQ_LOOP && !cont_r) |=> pc_r == PC_IDLE && out_final_write)
    else $error("final word did not end the command");
`endif

endmodule

// File: tb/circle_outline_and_fill_rasterizer_top_test.sv
`timescale 1ns / 100ps

module circle_outline_and_fill_rasterizer_top_test;
  import cofr_pkg::*;

  // One circle command word as it crosses the in_ channel.
  typedef struct {
    logic signed [OUT_W-1:0] pos_x;
    logic signed [OUT_W-1:0] pos_y;
    logic [DIAM_W-1:0]       diam;
    logic [ANC_W-1:0]        anchor;
    logic                    solid;
    logic [INK_W-1:0]        ink;
  } circle_cmd_t;

  // One pixel or span write word as it leaves on the out_ channel.
  typedef struct {
    logic [OUT_W-1:0] wx;
    logic [OUT_W-1:0] wy;
    logic [RUN_W-1:0] run;
    logic             span;
    logic [INK_W-1:0] ink;
    logic             last;
  } pixel_write_t;

  // Holds the writes that accepted commands must still produce, in order, and
  // compares every write word that the block hands out against the oldest one.
  class circle_write_board;
    pixel_write_t pending_writes[$];
    pixel_write_t held_write;
    bit           have_held;
    logic [OUT_W-1:0] base_x, base_y;
    logic             fill_mode;
    logic [INK_W-1:0] ink_reg;
    int errors;
    int commands;
    int drawn;
    int checked;

    function int pending();
      return pending_writes.size();
    endfunction

    // A write is held back one place so that the last one of a command can
    // carry the final flag once the walk has ended.
    function void add_write(logic [OUT_W-1:0] x, logic [OUT_W-1:0] y, int len);
      pixel_write_t w;
      w.wx   = x;
      w.wy   = y;
      w.run  = RUN_W'(len);
      w.span = fill_mode;
      w.ink  = ink_reg;
      w.last = 1'b0;
      if (have_held) pending_writes.push_back(held_write);
      held_write = w;
      have_held  = 1'b1;
    endfunction

    function void note_command(circle_cmd_t c);
      logic [OUT_W-1:0] px, py, dw, hw, lx, ty, rx, by, ux, uy, ay;
      logic even;
      int h, rr, thr, xo, yo, per, n;
      commands++;
      if (c.diam == '0 || c.diam > DIAM_W'(MAX_DIAMETER) || c.anchor > ANC_CTR) return;
      drawn++;
      px = c.pos_x;
      py = c.pos_y;
      h  = int'(c.diam) / 2;
      dw = OUT_W'(c.diam);
      hw = OUT_W'(h);
      even = ~c.diam[0];
      fill_mode = c.solid;
      ink_reg   = c.ink;
      if (even) begin
        base_x = (c.anchor == ANC_TR || c.anchor == ANC_BR) ? px - dw :
                 (c.anchor == ANC_CTR ? px - hw : px);
        base_y = (c.anchor == ANC_BL || c.anchor == ANC_BR) ? py - dw :
                 (c.anchor == ANC_CTR ? py - hw : py);
        thr = (h <= 3) ? 0 : ((h <= 6) ? 3 : 5);
        rr  = h - 1;
      end else begin
        base_x = (c.anchor == ANC_TL || c.anchor == ANC_BL) ? px + hw :
                 (c.anchor == ANC_CTR ? px : px - hw);
        base_y = (c.anchor == ANC_TL || c.anchor == ANC_TR) ? py + hw :
                 (c.anchor == ANC_CTR ? py : py - hw);
        thr = (h == 1) ? 0 : ((h == 2) ? 1 : ((h == 3) ? 3 : 5));
        rr  = h;
      end
      per = fill_mode ? 4 : 8;
      n   = 0;
      xo  = 0;
      yo  = -rr;
      lx  = base_x + hw - 16'd1;
      ty  = base_y + hw - 16'd1;
      rx  = base_x + hw;
      by  = base_y + hw;
      while (xo <= -yo && n + per <= MAX_WRITES) begin
        ux = OUT_W'(xo);
        uy = OUT_W'(yo);
        ay = OUT_W'(-yo);
        if (even && fill_mode) begin
          add_write(lx - ux, ty + uy, 2 * (xo + 1));
          add_write(lx + uy, ty - ux, 2 * (-yo + 1));
          add_write(lx - ux, by - uy, 2 * (xo + 1));
          add_write(lx + uy, by + ux, 2 * (-yo + 1));
        end else if (even) begin
          add_write(lx - ux, ty + uy, 1);
          add_write(lx + uy, ty - ux, 1);
          add_write(rx + ux, ty + uy, 1);
          add_write(rx - uy, ty - ux, 1);
          add_write(lx - ux, by - uy, 1);
          add_write(lx + uy, by + ux, 1);
          add_write(rx + ux, by - uy, 1);
          add_write(rx - uy, by + ux, 1);
        end else if (fill_mode) begin
          add_write(base_x - ux, base_y + uy, 2 * xo + 1);
          add_write(base_x + uy, base_y - ux, 2 * (-yo) + 1);
          add_write(base_x - ux, base_y - uy, 2 * xo + 1);
          add_write(base_x + uy, base_y + ux, 2 * (-yo) + 1);
        end else begin
          add_write(base_x + ux, base_y + uy, 1);
          add_write(base_x + ux, base_y - uy, 1);
          add_write(base_x - ux, base_y + uy, 1);
          add_write(base_x - ux, base_y - uy, 1);
          add_write(base_x + uy, base_y + ux, 1);
          add_write(base_x + uy, base_y - ux, 1);
          add_write(base_x - uy, base_y + ux, 1);
          add_write(base_x - uy, base_y - ux, 1);
        end
        n += per;
        xo++;
        if (xo * xo + yo * yo - rr * rr > thr) yo++;
      end
      if (have_held) begin
        held_write.last = 1'b1;
        pending_writes.push_back(held_write);
        have_held = 1'b0;
      end
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_write(pixel_write_t got);
      pixel_write_t want;
      checked++;
      if (pending_writes.size() == 0) begin
        $display("%0t: unexpected write, expected none, actual x %h y %h run %0d",
                 $time, got.wx, got.wy, got.run);
        errors++;
        return;
      end
      want = pending_writes.pop_front();
      compare_field("write_x", want.wx, got.wx);
      compare_field("write_y", want.wy, got.wy);
      compare_field("run_length", 16'(want.run), 16'(got.run));
      compare_field("is_span", 16'(want.span), 16'(got.span));
      compare_field("write_ink", want.ink, got.ink);
      compare_field("final_write", 16'(want.last), 16'(got.last));
    endfunction
  endclass

  // Cycles without any accepted word before the run is declared hung. The
  // slowest gap between two accepted words is a sender pause, a receiver stall
  // and the setup steps of a command, all far below this.
  localparam int HANG_LIMIT = 3000;
  localparam int RANDOM_DRAWS = 165;

  logic clk;
  logic rst_n;

  logic                    in_valid;
  logic                    in_stall;
  logic signed [OUT_W-1:0] in_pos_x;
  logic signed [OUT_W-1:0] in_pos_y;
  logic [DIAM_W-1:0]       in_diam;
  logic [ANC_W-1:0]        in_anchor;
  logic                    in_solid;
  logic [INK_W-1:0]        in_ink;

  logic                    out_valid;
  logic                    out_stall;
  logic signed [OUT_W-1:0] out_write_x;
  logic signed [OUT_W-1:0] out_write_y;
  logic [RUN_W-1:0]        out_run_length;
  logic                    out_is_span;
  logic [INK_W-1:0]        out_write_ink;
  logic                    out_final_write;

  circle_write_board board = new;

  // Phase switches: when set, that side never idles, so back-to-back words
  // are exercised as well as gaps on every cycle of a walk step.
  bit sender_eager;
  bit receiver_eager;
  int idle_cycles;

  circle_outline_and_fill_rasterizer_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_diam         (in_diam),
    .in_anchor       (in_anchor),
    .in_solid        (in_solid),
    .in_ink          (in_ink),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_write_x     (out_write_x),
    .out_write_y     (out_write_y),
    .out_run_length  (out_run_length),
    .out_is_span     (out_is_span),
    .out_write_ink   (out_write_ink),
    .out_final_write (out_final_write)
  );

  initial clk = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Both channels are watched at the clock edge. The driving processes only
  // use nonblocking assignments, so the values seen here are the ones that
  // were present when the edge came, which is when a word is taken.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        circle_cmd_t c;
        c.pos_x  = in_pos_x;
        c.pos_y  = in_pos_y;
        c.diam   = in_diam;
        c.anchor = in_anchor;
        c.solid  = in_solid;
        c.ink    = in_ink;
        board.note_command(c);
      end
      if (out_valid && !out_stall) begin
        pixel_write_t w;
        w.wx   = out_write_x;
        w.wy   = out_write_y;
        w.run  = out_run_length;
        w.span = out_is_span;
        w.ink  = out_write_ink;
        w.last = out_final_write;
        board.check_write(w);
      end
    end
  end

  // Count cycles in which neither channel moved a word.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= HANG_LIMIT);
    $display("%0t: no word moved for %0d cycles, %0d writes still owed",
             $time, HANG_LIMIT, board.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: before each write word it may hold stall high for a random
  // number of cycles, then keeps stall low until that word has been taken.
  initial begin
    int hold;
    out_stall <= 1'b0;
    forever begin
      hold = receiver_eager ? 0 : $urandom_range(0, 11);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && !out_stall));
    end
  end

  // Present one command word and return at the edge that takes it. Valid is
  // left high on return so a following command with no gap keeps it high.
  task automatic issue_command(circle_cmd_t c);
    int gap;
    gap = sender_eager ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_pos_x  <= c.pos_x;
    in_pos_y  <= c.pos_y;
    in_diam   <= c.diam;
    in_anchor <= c.anchor;
    in_solid  <= c.solid;
    in_ink    <= c.ink;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic draw_circle(int x, int y, int d, int a, bit s, int ink);
    circle_cmd_t c;
    c.pos_x  = OUT_W'(x);
    c.pos_y  = OUT_W'(y);
    c.diam   = DIAM_W'(d);
    c.anchor = ANC_W'(a);
    c.solid  = s;
    c.ink    = INK_W'(ink);
    issue_command(c);
  endtask

  // Stop sending until every owed write has come back. Valid is dropped in
  // the same step so the block sees an empty input while it drains. The task
  // first waits for the next edge so that the monitor has booked the command
  // taken at the edge where the caller returned.
  task automatic drain_writes();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Mostly well-formed circles with random content; about one in ten is a
  // command the block must drop: zero or oversize diameter, or a bad anchor.
  task automatic random_command();
    circle_cmd_t c;
    c.pos_x  = OUT_W'($urandom);
    c.pos_y  = OUT_W'($urandom);
    c.diam   = DIAM_W'($urandom_range(1, MAX_DIAMETER));
    c.anchor = ANC_W'($urandom_range(ANC_TL, ANC_CTR));
    c.solid  = 1'($urandom_range(0, 1));
    c.ink    = INK_W'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 2))
        0: c.diam = '0;
        1: c.diam = DIAM_W'($urandom_range(MAX_DIAMETER + 1, 31));
        default: c.anchor = ANC_W'($urandom_range(ANC_CTR + 1, 7));
      endcase
    end
    issue_command(c);
  endtask

  initial begin
    int drawn_target;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_pos_x  <= '0;
    in_pos_y  <= '0;
    in_diam   <= '0;
    in_anchor <= '0;
    in_solid  <= 1'b0;
    in_ink    <= '0;
    sender_eager   = 1'b0;
    receiver_eager = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A zero diameter draws nothing; diameter one puts every
    // write on the centre pixel; diameter two is the smallest even circle.
    draw_circle(0, 0, 0, ANC_CTR, 1'b0, 16'h1234);
    draw_circle(100, 50, 1, ANC_CTR, 1'b0, 16'hffff);
    draw_circle(100, 50, 1, ANC_CTR, 1'b1, 16'h0000);
    for (int a = ANC_TL; a <= ANC_CTR; a++)
      draw_circle(-20, 30, 2, a, a[0], 16'h00ff + a);
    for (int a = ANC_TL; a <= ANC_CTR; a++)
      draw_circle(40, -7, 7, a, ~a[0], 16'hf00f - a);
    // Largest circles placed at the coordinate limits, so that anchor resolution
    // or the writes wrap across a limit.
    draw_circle(32767, 32767, 20, ANC_CTR, 1'b0, 16'h8001);
    draw_circle(-32768, -32768, 20, ANC_TL, 1'b1, 16'h7ffe);
    draw_circle(-32768, 32767, 19, ANC_BR, 1'b0, 16'haaaa);
    draw_circle(32767, -32768, 19, ANC_TR, 1'b1, 16'h5555);
    // Commands that the block must drop without a single write.
    draw_circle(5, 5, 21, ANC_CTR, 1'b0, 16'h0001);
    draw_circle(5, 5, 31, ANC_TL, 1'b1, 16'h0002);
    draw_circle(5, 5, 6, 5, 1'b0, 16'h0003);
    draw_circle(5, 5, 6, 7, 1'b1, 16'h0004);
    // Radii in the two lowest even step threshold bands and the lowest odd one.
    draw_circle(-1, -1, 4, ANC_BL, 1'b0, 16'h5555);
    draw_circle(1, 1, 12, ANC_CTR, 1'b1, 16'haaaa);
    draw_circle(-300, 300, 3, ANC_CTR, 1'b1, 16'hc3c3);
    drain_writes();

    // Random part, with one stretch where the sender never idles, one where
    // the receiver never stalls, and a full drain in the middle.
    drawn_target = board.drawn + RANDOM_DRAWS;
    for (int i = 0; board.drawn < drawn_target; i++) begin
      sender_eager   = (i >= 40 && i < 75);
      receiver_eager = (i >= 100 && i < 140);
      if (i == 150) drain_writes();
      random_command();
    end
    sender_eager   = 1'b0;
    receiver_eager = 1'b0;

    // Wait for the owed writes, then a little longer so a stray extra write
    // would still be caught.
    drain_writes();
    repeat (80) @(posedge clk);

    $display("Sent %0d circle commands (%0d drawn, %0d dropped), checked %0d write words.",
             board.commands, board.drawn, board.commands - board.drawn, board.checked);
    if (board.errors == 0 && board.pending() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
